// ===== design/mbsu_pkg.sv =====
package mbsu_pkg;

    localparam logic [7:0] C_STATUS_MIN  = 8'h80;
    localparam logic [7:0] C_SYSEX_START = 8'hF0;
    localparam logic [3:0] C_KIND_SYSTEM = 4'hF;
    localparam logic [3:0] C_KIND_PROG   = 4'hC;
    localparam logic [3:0] C_KIND_PRESS  = 4'hD;
    localparam logic [3:0] C_CIN_SYSEX   = 4'h4;
    localparam logic [3:0] C_CIN_SINGLE  = 4'h5;

    localparam logic [1:0] C_NEED_IDLE = 2'd0;
    localparam logic [1:0] C_NEED_ONE  = 2'd1;
    localparam logic [1:0] C_NEED_TWO  = 2'd2;

    typedef struct packed {
        logic [7:0] serial_byte;
        logic       end_of_buffer;
        logic       host_ready;
    } t_in_item;

    typedef struct packed {
        logic [7:0] packet_header;
        logic [7:0] packet_byte_one;
        logic [7:0] packet_byte_two;
        logic [7:0] packet_byte_three;
    } t_out_item;

    typedef struct packed {
        logic [7:0] held_status;
        logic [1:0] bytes_still_needed;
        logic [7:0] held_first_data;
    } t_enc_state;

endpackage

// ===== design/mbsu_encoder.sv =====
module mbsu_encoder
    import mbsu_pkg::*;
(
    input  t_enc_state i_state,
    input  t_in_item   i_item,
    input  logic [3:0] i_cable,
    output t_enc_state o_state,
    output logic       o_emit,
    output t_out_item  o_packet
);

    logic [3:0] w_code;
    logic [3:0] w_kind;
    logic [3:0] w_held_kind;

    assign w_kind      = i_item.serial_byte[7:4];
    assign w_held_kind = i_state.held_status[7:4];

    always_comb begin
        o_state  = i_state;
        o_emit   = 1'b0;
        w_code   = w_held_kind;
        o_packet = '0;
        case (i_state.bytes_still_needed)
            C_NEED_TWO: begin
                o_state.held_first_data    = i_item.serial_byte;
                o_state.bytes_still_needed = C_NEED_ONE;
            end
            C_NEED_ONE: begin
                o_state.bytes_still_needed = C_NEED_IDLE;
                o_emit                     = 1'b1;
                w_code                     = w_held_kind;
                o_packet.packet_byte_one   = i_state.held_status;
                if (w_held_kind == C_KIND_PROG || w_held_kind == C_KIND_PRESS) begin
                    o_packet.packet_byte_two = i_item.serial_byte;
                end else begin
                    o_packet.packet_byte_two   = i_state.held_first_data;
                    o_packet.packet_byte_three = i_item.serial_byte;
                end
            end
            default: begin
                // idle, and the unused count value too
                o_state.bytes_still_needed = C_NEED_IDLE;
                if (i_item.serial_byte >= C_STATUS_MIN) begin
                    if (w_kind == C_KIND_SYSTEM) begin
                        o_emit                   = 1'b1;
                        w_code                   = (i_item.serial_byte == C_SYSEX_START)
                                                   ? C_CIN_SYSEX : C_CIN_SINGLE;
                        o_packet.packet_byte_one = i_item.serial_byte;
                    end else if (w_kind == C_KIND_PROG || w_kind == C_KIND_PRESS) begin
                        o_state.held_status        = i_item.serial_byte;
                        o_state.bytes_still_needed = C_NEED_ONE;
                    end else begin
                        o_state.held_status        = i_item.serial_byte;
                        o_state.held_first_data    = 8'h00;
                        o_state.bytes_still_needed = C_NEED_TWO;
                    end
                end
            end
        endcase
        o_packet.packet_header = {i_cable, w_code};
        // drop the pending message at a buffer boundary
        if (i_item.end_of_buffer) begin
            o_state.bytes_still_needed = C_NEED_IDLE;
        end
        // drop the packet when the host side cannot take it
        if (!i_item.host_ready) begin
            o_emit = 1'b0;
        end
    end

endmodule

// ===== design/midi_byte_stream_to_usb_packets.sv =====
// A packet is registered and appears on the output in the cycle after its last byte is accepted.
// Throughput: one byte per cycle; the single output register stalls input only
// while a packet waits on a low output ready.
// Reset (synchronous, active low): cable number 0, encoder idle, no packet pending.
module midi_byte_stream_to_usb_packets
    import mbsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_item,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data
);

    t_enc_state r_state;
    t_enc_state n_state;
    logic [3:0] r_cable;
    logic       r_out_valid;
    t_out_item  r_out_item;
    t_out_item  n_out_item;
    logic       w_emit;
    logic       w_in_acc;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    mbsu_encoder u_encoder (
        .i_state  (r_state),
        .i_item   (i_in_item),
        .i_cable  (r_cable),
        .o_state  (n_state),
        .o_emit   (w_emit),
        .o_packet (n_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_cable     <= 4'h0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cable <= i_cfg_data;
            end
            if (w_in_acc) begin
                r_state     <= n_state;
                r_out_valid <= w_emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_emit) begin
            r_out_item <= n_out_item;
        end
    end

    a_count_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bytes_still_needed != 2'd3)
        else $error("byte count reached unused value");

    a_eob_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_item.end_of_buffer) |=> (r_state.bytes_still_needed == C_NEED_IDLE))
        else $error("pending message survived end of buffer");

    a_host_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_in_item.host_ready) |=> !r_out_valid)
        else $error("packet produced while host not ready");

    a_first_data_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_state.bytes_still_needed == C_NEED_TWO) |=> !r_out_valid)
        else $error("packet produced on first data byte");

endmodule

// ===== dv/midi_byte_stream_to_usb_packets_tb.sv =====
module midi_byte_stream_to_usb_packets_tb
    import mbsu_pkg::*;
;

    class packet_scoreboard;
        logic [3:0] cable;
        logic [7:0] held_status;
        logic [1:0] still_needed;
        logic [7:0] held_first;
        t_out_item  expected_packets[$];
        int         mismatches;
        int         bytes_seen;
        int         packets_seen;

        function new();
            cable        = 4'd0;
            held_status  = 8'd0;
            still_needed = C_NEED_IDLE;
            held_first   = 8'd0;
            mismatches   = 0;
            bytes_seen   = 0;
            packets_seen = 0;
        endfunction

        function void set_cable(logic [3:0] value);
            cable = value;
        endfunction

        function int pending();
            return expected_packets.size();
        endfunction

        // Advance the encoder state by one byte and queue the packet it completes if the host is ready.
        function void note_byte(t_in_item req);
            t_out_item  pkt;
            logic [3:0] cin;
            logic [7:0] b;
            bit         done;
            b    = req.serial_byte;
            pkt  = '0;
            cin  = 4'd0;
            done = 0;
            bytes_seen++;
            case (still_needed)
                C_NEED_TWO: begin
                    held_first   = b;
                    still_needed = C_NEED_ONE;
                end
                C_NEED_ONE: begin
                    still_needed        = C_NEED_IDLE;
                    cin                 = held_status[7:4];
                    done                = 1;
                    pkt.packet_byte_one = held_status;
                    if (cin == C_KIND_PROG || cin == C_KIND_PRESS) begin
                        pkt.packet_byte_two   = b;
                        pkt.packet_byte_three = 8'd0;
                    end else begin
                        pkt.packet_byte_two   = held_first;
                        pkt.packet_byte_three = b;
                    end
                end
                default: begin
                    // the unused count behaves as idle
                    still_needed = C_NEED_IDLE;
                    if (b >= C_STATUS_MIN) begin
                        if (b[7:4] == C_KIND_SYSTEM) begin
                            done                = 1;
                            cin = (b == C_SYSEX_START) ? C_CIN_SYSEX : C_CIN_SINGLE;
                            pkt.packet_byte_one = b;
                        end else if (b[7:4] == C_KIND_PROG || b[7:4] == C_KIND_PRESS) begin
                            held_status  = b;
                            still_needed = C_NEED_ONE;
                        end else begin
                            held_status  = b;
                            held_first   = 8'd0;
                            still_needed = C_NEED_TWO;
                        end
                    end
                end
            endcase
            if (req.end_of_buffer)
                still_needed = C_NEED_IDLE;
            if (done && req.host_ready) begin
                pkt.packet_header = {cable, cin};
                expected_packets.push_back(pkt);
            end
        endfunction

        function void check_packet(t_out_item got);
            t_out_item want;
            packets_seen++;
            if (expected_packets.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected packet %h %h %h %h", got.packet_header,
                             got.packet_byte_one, got.packet_byte_two,
                             got.packet_byte_three);
                return;
            end
            want = expected_packets.pop_front();
            if (got.packet_header !== want.packet_header
                    || got.packet_byte_one !== want.packet_byte_one
                    || got.packet_byte_two !== want.packet_byte_two
                    || got.packet_byte_three !== want.packet_byte_three) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("packet mismatch: expected %h %h %h %h, got %h %h %h %h",
                             want.packet_header, want.packet_byte_one,
                             want.packet_byte_two, want.packet_byte_three,
                             got.packet_header, got.packet_byte_one,
                             got.packet_byte_two, got.packet_byte_three);
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_item   i_in_item;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_item  o_out_item;
    logic       i_cfg_we;
    logic [3:0] i_cfg_data;

    packet_scoreboard sb = new();
    int send_idle_pct;
    int recv_stall_pct;

    midi_byte_stream_to_usb_packets dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("midi_byte_stream_to_usb_packets regression: fail");
        $finish;
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_packet(o_out_item);
            if (i_in_valid && o_in_ready)
                sb.note_byte(i_in_item);
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit eob, input bit rdy);
        t_in_item req;
        req.serial_byte   = b;
        req.end_of_buffer = eob;
        req.host_ready    = rdy;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        // hold the request until it is taken
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_and_write_cable(input logic [3:0] value);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        sb.set_cable(value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [7:0] random_data();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 127));
    endfunction

    task automatic send_channel_message();
        logic [7:0] status;
        status[7:4] = 4'($urandom_range(8, 14));
        status[3:0] = 4'($urandom_range(0, 15));
        send_byte(status, $urandom_range(0, 99) < 3, 1'($urandom_range(0, 1)));
        if (status[7:4] != C_KIND_PROG && status[7:4] != C_KIND_PRESS)
            send_byte(random_data(), $urandom_range(0, 99) < 3, 1'($urandom_range(0, 1)));
        send_byte(random_data(), $urandom_range(0, 99) < 15, $urandom_range(0, 99) < 90);
    endtask

    task automatic send_random_stream(input int count);
        int target;
        int pick;
        target = sb.bytes_seen + count;
        while (sb.bytes_seen < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_channel_message();
            else if (pick < 85)
                send_byte(($urandom_range(0, 3) == 0) ? C_SYSEX_START
                          : {C_KIND_SYSTEM, 4'($urandom_range(0, 15))},
                          1'($urandom_range(0, 1)), $urandom_range(0, 99) < 90);
            else
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
        end
        // close the chunk so the encoder is idle before the next write
        send_byte(8'h00, 1'b1, 1'b1);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_item      = '0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = 4'd0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset cable number
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'h7F, 1'b1, 1'b1);
        send_byte(8'h90, 1'b0, 1'b1);
        send_byte(8'h3C, 1'b0, 1'b1);
        send_byte(8'h7F, 1'b0, 1'b1);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hEF, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'hC5, 1'b0, 1'b1);
        send_byte(8'h80, 1'b0, 1'b1);
        send_byte(8'hDF, 1'b0, 1'b1);
        send_byte(8'h7F, 1'b1, 1'b1);
        send_byte(8'hF0, 1'b0, 1'b1);
        send_byte(8'hF7, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hB0, 1'b0, 1'b1);
        send_byte(8'h07, 1'b0, 1'b1);
        send_byte(8'h64, 1'b0, 1'b0);
        send_byte(8'hA3, 1'b1, 1'b1);
        send_byte(8'h10, 1'b0, 1'b1);
        send_byte(8'h92, 1'b0, 1'b1);
        send_byte(8'h40, 1'b1, 1'b1);
        send_byte(8'h41, 1'b0, 1'b1);

        drain_and_write_cable(4'hF);
        send_idle_pct  = 8;
        recv_stall_pct = 66;
        send_random_stream(165);

        drain_and_write_cable(4'($urandom_range(1, 14)));
        send_idle_pct  = 66;
        recv_stall_pct = 8;
        send_random_stream(165);

        drain_and_write_cable(4'h0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_stream(165);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("covered %0d serial bytes and %0d packets over cable numbers %s",
                 sb.bytes_seen, sb.packets_seen, "0, 15 and one between");
        $display("handshake mixes: slow receiver, slow sender, full rate; %0d mismatches",
                 sb.mismatches + sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("midi_byte_stream_to_usb_packets regression: pass");
        end else begin
            $display("midi_byte_stream_to_usb_packets regression: fail");
        end
        $finish;
    end

endmodule

// ===== midi_byte_stream_to_usb_packets.f =====
design/mbsu_pkg.sv
design/mbsu_encoder.sv
design/midi_byte_stream_to_usb_packets.sv
dv/midi_byte_stream_to_usb_packets_tb.sv
